### rtl/core/byte_substring_search_defines.svh
// Assertion macros shared by the byte substring search RTL.
// Included by files that check clocked properties; needs clk and rst_n in scope.
`ifndef BYTE_SUBSTRING_SEARCH_DEFINES_SVH
`define BYTE_SUBSTRING_SEARCH_DEFINES_SVH

// Check that cond implies result in the same cycle.
`define BSS_ASSERT_SAME(lbl, cond, result, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (result)) \
        else $error(msg);

// Check that cond implies result in the next cycle.
`define BSS_ASSERT_NEXT(lbl, cond, result, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
        else $error(msg);

`endif

### rtl/core/bss_pkg.sv
// Package for the byte substring search: word types, field codes and defaults.
// No dependencies.
package bss_pkg;

    localparam int PATTERN_MAX_DEF = 64;
    localparam int OFFSET_BITS_DEF = 16;

    localparam int LEN_BITS    = 7;
    localparam int INDEX_BITS  = 6;
    localparam int BYTE_BITS   = 8;
    localparam int OFFSET_OUT  = 16;
    localparam int APB_DATA    = 32;
    localparam int APB_ADDR    = 3;

    localparam logic [LEN_BITS-1:0]   LEN_RESET      = 7'd1;
    localparam logic [BYTE_BITS-1:0]  BYTE_MASK      = 8'hff;
    localparam logic [OFFSET_OUT-1:0] OFFSET_OUT_MAX = 16'hffff;

    typedef enum logic
    {
        FUNC_LOAD = 1'b0,
        FUNC_DATA = 1'b1
    } func_t;

    typedef enum logic
    {
        REG_PATTERN_LENGTH = 1'b0,
        REG_UNUSED         = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        func_t                  func;
        logic [INDEX_BITS-1:0]  pattern_index;
        logic [BYTE_BITS-1:0]   byte_value;
        logic                   last_byte;
    } in_word_t;

    typedef struct packed
    {
        logic                   found;
        logic [OFFSET_OUT-1:0]  match_offset;
    } out_word_t;

endpackage

### rtl/core/byte_substring_search.sv
// Byte substring search: pattern store, byte window and parallel compare.
// Depends on bss_pkg and byte_substring_search_defines.svh.
// The compare follows the input register; a result is captured in the result register.
// Throughput: one word per cycle; the only stall is a held result on the output.
// Reset clears window, byte count, match flag and both valids; pattern_length resets to 1.
// The pattern store has no reset.
`include "byte_substring_search_defines.svh"

module byte_substring_search #(
    parameter int PATTERN_MAX = bss_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = bss_pkg::OFFSET_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bss_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bss_pkg::out_word_t            out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bss_pkg::APB_ADDR-1:0]  paddr,
    input  logic [bss_pkg::APB_DATA-1:0]  pwdata,
    output logic [bss_pkg::APB_DATA-1:0]  prdata,
    output logic                          pready
);

    import bss_pkg::*;

    localparam int WIN_BITS  = PATTERN_MAX * BYTE_BITS;
    localparam int PIDX_BITS = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int SH_BITS   = $clog2(PATTERN_MAX + 1);
    localparam int CMP_BITS  = ((SH_BITS > LEN_BITS) ? SH_BITS : LEN_BITS) + 1;
    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

    logic [LEN_BITS-1:0]     len_reg;
    logic                    s1_valid_reg;
    in_word_t                s1_word_reg;
    logic                    out_valid_reg;
    out_word_t               out_word_reg;
    logic [BYTE_BITS-1:0]    pattern_mem [PATTERN_MAX];
    logic [WIN_BITS-1:0]     win_reg;
    logic [WIN_BITS-1:0]     win_next;
    logic [OFFSET_BITS-1:0]  count_reg;
    logic [OFFSET_BITS-1:0]  count_next;
    logic                    match_seen_reg;
    logic                    match_seen_next;

    logic                    advance;
    logic                    cfg_write;
    logic                    s1_data;
    logic                    s1_load;
    logic [31:0]             idx_ext;
    logic [PIDX_BITS-1:0]    wr_addr;
    logic [WIN_BITS-1:0]     rev_win;
    logic [WIN_BITS-1:0]     aligned;
    logic [CMP_BITS-1:0]     len_ext;
    logic [CMP_BITS-1:0]     diff;
    logic [SH_BITS-1:0]      shamt;
    logic                    len_ok;
    logic                    enough;
    logic [PATTERN_MAX-1:0]  byte_ok;
    logic                    hit;
    logic                    res_gen;
    logic [OFFSET_BITS-1:0]  off_raw;
    logic [31:0]             off_ext;
    out_word_t               res_word;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign s1_data  = s1_valid_reg && (s1_word_reg.func == FUNC_DATA);
    assign s1_load  = s1_valid_reg && (s1_word_reg.func == FUNC_LOAD);

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (reg_idx_t'(paddr[APB_ADDR-1]) == REG_PATTERN_LENGTH);

    always_comb
    begin
        case (reg_idx_t'(paddr[APB_ADDR-1]))
            REG_PATTERN_LENGTH: prdata = APB_DATA'(len_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else if (cfg_write)
        begin
            len_reg <= pwdata[LEN_BITS-1:0];
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_word_reg <= in_data;
        end
    end

    // pattern store write
    assign idx_ext = 32'(s1_word_reg.pattern_index);
    assign wr_addr = idx_ext[PIDX_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (advance && s1_load && (idx_ext < 32'(PATTERN_MAX)))
        begin
            pattern_mem[wr_addr] <= s1_word_reg.byte_value;
        end
    end

    // window shift and compare
    always_comb
    begin
        win_next = (win_reg << BYTE_BITS) | WIN_BITS'(s1_word_reg.byte_value & BYTE_MASK);
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            rev_win[k*BYTE_BITS +: BYTE_BITS] =
                win_next[(PATTERN_MAX-1-k)*BYTE_BITS +: BYTE_BITS];
        end
    end

    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign len_ext    = CMP_BITS'(len_reg);
    assign len_ok     = len_ext <= CMP_BITS'(PATTERN_MAX);
    assign diff       = CMP_BITS'(PATTERN_MAX) - len_ext;
    assign shamt      = diff[SH_BITS-1:0];
    assign aligned    = rev_win >> {shamt, 3'b000};
    assign enough     = 32'(count_next) >= 32'(len_reg);

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            byte_ok[i] = (32'(i) >= 32'(len_reg))
                         || (pattern_mem[i] == aligned[i*BYTE_BITS +: BYTE_BITS]);
        end
    end

    assign hit     = (len_reg == '0) || (len_ok && enough && (&byte_ok));
    assign res_gen = s1_data && !match_seen_reg && (hit || s1_word_reg.last_byte);
    assign off_raw = (len_reg == '0) ? '0 : count_next - OFFSET_BITS'(len_reg);
    assign off_ext = 32'(off_raw);

    always_comb
    begin
        res_word.found = hit;
        if (!hit)
        begin
            res_word.match_offset = '0;
        end
        else if (off_ext > 32'(OFFSET_OUT_MAX))
        begin
            res_word.match_offset = OFFSET_OUT_MAX;
        end
        else
        begin
            res_word.match_offset = off_ext[OFFSET_OUT-1:0];
        end
    end

    always_comb
    begin
        match_seen_next = match_seen_reg || (s1_data && hit);
        if (s1_word_reg.last_byte)
        begin
            match_seen_next = 1'b0;
        end
    end

    // search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg        <= '0;
            count_reg      <= '0;
            match_seen_reg <= 1'b0;
        end
        else if (advance && s1_data)
        begin
            if (s1_word_reg.last_byte)
            begin
                win_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                win_reg   <= win_next;
                count_reg <= count_next;
            end
            match_seen_reg <= match_seen_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_gen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_gen)
        begin
            out_word_reg <= res_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    `BSS_ASSERT_SAME(a_stall_only_on_output, !in_ready, out_valid_reg && !out_ready,
                     "input stalled without a held result")
    `BSS_ASSERT_SAME(a_one_result_per_buffer, s1_data && match_seen_reg, !res_gen,
                     "second result after a match")
    `BSS_ASSERT_NEXT(a_clear_on_last, advance && s1_data && s1_word_reg.last_byte,
                     (count_reg == '0) && !match_seen_reg, "search state not cleared")

endmodule

### tb/sv/tb_byte_substring_search.sv
// Self-checking testbench for byte_substring_search: streams pattern loads and buffer bytes,
// predicts the search results and checks them, with randomized idling on both channels.
// Depends on bss_pkg and the byte_substring_search RTL.
`timescale 1ns / 100ps

module tb_byte_substring_search;

    import bss_pkg::*;

    localparam int                  LONG_HOLD  = 400;
    localparam int                  LONG_BYTES = 80;
    localparam logic [APB_ADDR-1:0] LEN_ADDR   = APB_ADDR'(4 * int'(REG_PATTERN_LENGTH));

    class search_scoreboard;
        logic [BYTE_BITS-1:0]       pattern_bytes [PATTERN_MAX_DEF];
        logic [BYTE_BITS-1:0]       recent_bytes [PATTERN_MAX_DEF];
        logic [OFFSET_BITS_DEF-1:0] bytes_seen;
        bit                         matched;
        logic [LEN_BITS-1:0]        match_len;
        out_word_t                  awaited [$];
        int                         mismatches;
        int                         results_checked;

        function new();
            foreach (pattern_bytes[k])
                pattern_bytes[k] = '0;
            clear_buffer();
            match_len = LEN_RESET;
        endfunction

        function void clear_buffer();
            foreach (recent_bytes[k])
                recent_bytes[k] = '0;
            bytes_seen = '0;
            matched = 1'b0;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 100)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void note_word(in_word_t w);
            bit                    hit;
            logic [OFFSET_OUT-1:0] start;
            out_word_t             res;
            if (w.func == FUNC_LOAD)
            begin
                pattern_bytes[w.pattern_index] = w.byte_value;
                return;
            end
            for (int k = PATTERN_MAX_DEF - 1; k > 0; k--)
                recent_bytes[k] = recent_bytes[k - 1];
            recent_bytes[0] = w.byte_value;
            if (bytes_seen != '1)
                bytes_seen++;
            if (!matched)
            begin
                hit = 1'b0;
                start = '0;
                if (match_len == 0)
                    hit = 1'b1;
                else if (match_len <= PATTERN_MAX_DEF && bytes_seen >= match_len)
                begin
                    hit = 1'b1;
                    for (int i = 0; i < match_len; i++)
                        if (pattern_bytes[i] !== recent_bytes[match_len - 1 - i])
                            hit = 1'b0;
                    start = OFFSET_OUT'(bytes_seen - match_len);
                end
                if (hit)
                begin
                    res.found = 1'b1;
                    res.match_offset = start;
                    awaited.push_back(res);
                    matched = 1'b1;
                end
                else if (w.last_byte)
                begin
                    res.found = 1'b0;
                    res.match_offset = '0;
                    awaited.push_back(res);
                end
            end
            if (w.last_byte)
                clear_buffer();
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            results_checked++;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result found=%0d offset=%0d",
                                 got.found, got.match_offset));
                return;
            end
            want = awaited.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %0d, expected %0d", got.found, want.found));
            if (got.match_offset !== want.match_offset)
                report($sformatf("match_offset %0d, expected %0d",
                                 got.match_offset, want.match_offset));
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    in_word_t            in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_word_t           out_data;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_ADDR-1:0] paddr     = '0;
    logic [APB_DATA-1:0] pwdata    = '0;
    logic [APB_DATA-1:0] prdata;
    logic                pready;

    search_scoreboard     sb;
    logic [BYTE_BITS-1:0] pattern_mirror [PATTERN_MAX_DEF];
    int                   cur_len      = 1;
    int                   words_sent   = 0;
    int                   lengths_set  = 0;
    int                   tx_idle_pct  = 0;
    int                   rx_stall_pct = 0;
    int                   hold_left    = 0;
    bit                   hold_req     = 1'b0;
    bit                   hold_served  = 1'b0;

    byte_substring_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_word(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    // hold off once for a long stretch on request, else stall at random
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_served)
        begin
            out_ready   <= 1'b0;
            hold_left   <= LONG_HOLD;
            hold_served <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    task automatic send_load(input logic [INDEX_BITS-1:0] idx, input logic [BYTE_BITS-1:0] val,
                             input logic last);
        in_word_t w;
        w.func          = FUNC_LOAD;
        w.pattern_index = idx;
        w.byte_value    = val;
        w.last_byte     = last;
        pattern_mirror[idx] = val;
        send_word(w);
    endtask

    task automatic send_data(input logic [BYTE_BITS-1:0] val, input logic last);
        in_word_t w;
        w.func          = FUNC_DATA;
        w.pattern_index = INDEX_BITS'($urandom_range(63));
        w.byte_value    = val;
        w.last_byte     = last;
        send_word(w);
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // write pattern_length, then read it back in the same bus transaction pair
    task automatic set_length(input logic [LEN_BITS-1:0] len);
        wait_quiet();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LEN_ADDR;
        pwdata  <= APB_DATA'(len);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.match_len = len;
        cur_len = int'(len);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DATA'(len))
            sb.report($sformatf("pattern_length reads %0d, expected %0d", prdata, len));
        psel    <= 1'b0;
        penable <= 1'b0;
        lengths_set++;
    endtask

    task automatic search_buffer();
        logic [BYTE_BITS-1:0] planted [PATTERN_MAX_DEF];
        int                   span;
        int                   blen;
        int                   pos;
        bit                   plant;
        bit                   spoil;
        logic [BYTE_BITS-1:0] v;
        span = (cur_len >= 1 && cur_len <= PATTERN_MAX_DEF) ? cur_len : 4;
        blen = span + $urandom_range(span < 8 ? 30 : 12);
        if ($urandom_range(9) == 0)
            blen = $urandom_range(span, 1);
        plant = (cur_len >= 1 && cur_len <= PATTERN_MAX_DEF && blen >= cur_len
                 && $urandom_range(99) < 65);
        spoil = ($urandom_range(99) < 20);
        pos = plant ? $urandom_range(blen - cur_len) : 0;
        foreach (planted[k])
            planted[k] = pattern_mirror[k];
        for (int k = 0; k < blen; k++)
        begin
            if ($urandom_range(99) < 4)
                send_load(INDEX_BITS'($urandom_range(63)), BYTE_BITS'($urandom_range(255)),
                          1'($urandom_range(1)));
            if (plant && k >= pos && k < pos + cur_len)
            begin
                v = planted[k - pos];
                if (spoil && k == pos + cur_len - 1)
                    v ^= BYTE_BITS'(1 << $urandom_range(7));
            end
            else if ($urandom_range(1))
                v = planted[$urandom_range(span - 1)];
            else
                v = BYTE_BITS'($urandom_range(255));
            send_data(v, k == blen - 1);
        end
    endtask

    task automatic random_traffic(input int target);
        int r;
        while (words_sent < target)
        begin
            if ($urandom_range(99) < 12)
            begin
                r = $urandom_range(99);
                if (r < 50)
                    set_length(LEN_BITS'($urandom_range(4, 1)));
                else if (r < 75)
                    set_length(LEN_BITS'($urandom_range(16, 5)));
                else if (r < 88)
                    set_length(LEN_BITS'($urandom_range(63, 17)));
                else if (r < 94)
                    set_length(LEN_BITS'(PATTERN_MAX_DEF));
                else if (r < 97)
                    set_length('0);
                else
                    set_length(LEN_BITS'($urandom_range(127, 65)));
            end
            if ($urandom_range(99) < 25)
                repeat ($urandom_range(4, 1))
                    send_load(INDEX_BITS'($urandom_range(63)), BYTE_BITS'($urandom_range(255)),
                              1'($urandom_range(1)));
            search_buffer();
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("[byte_substring_search] ERROR");
        $finish;
    end

    initial
    begin
        int guard;
        sb = new();
        foreach (pattern_mirror[k])
            pattern_mirror[k] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole pattern store before any compare reads it
        for (int k = 0; k < PATTERN_MAX_DEF; k++)
            send_load(INDEX_BITS'(k), BYTE_BITS'($urandom_range(255)), 1'($urandom_range(1)));

        // reset length of one
        send_load('0, 8'h00, 1'b1);
        send_load(6'd63, 8'hff, 1'b0);
        send_data(8'hff, 1'b0);
        send_data(8'h00, 1'b0);
        send_data(8'h00, 1'b1);
        send_data(8'hff, 1'b1);
        send_data(8'h00, 1'b1);
        // empty pattern
        set_length('0);
        send_data(8'h5a, 1'b0);
        send_data(8'ha5, 1'b1);
        send_data(8'h01, 1'b1);
        // match on the last byte, then a buffer too short to match
        set_length(7'd2);
        send_load('0, 8'hc3, 1'b0);
        send_load(6'd1, 8'h3c, 1'b1);
        send_data(8'hc3, 1'b0);
        send_data(8'hc3, 1'b0);
        send_data(8'h3c, 1'b1);
        send_data(8'hc3, 1'b1);
        // lengths beyond the store never match
        set_length(7'd65);
        send_data(8'hc3, 1'b0);
        send_data(8'h3c, 1'b1);
        set_length(7'd127);
        send_data(8'hc3, 1'b1);

        // one long buffer with a late match
        set_length(7'd3);
        send_load('0, 8'h11, 1'b0);
        send_load(6'd1, 8'h22, 1'b0);
        send_load(6'd2, 8'h33, 1'b0);
        repeat (LONG_BYTES)
            send_data(8'h44, 1'b0);
        send_data(8'h11, 1'b0);
        send_data(8'h22, 1'b0);
        send_data(8'h33, 1'b1);

        // long receiver hold-off with one result per word
        set_length(7'd1);
        send_load('0, 8'h7e, 1'b0);
        hold_req <= 1'b1;
        repeat (150)
            send_data($urandom_range(1) ? 8'h7e : BYTE_BITS'($urandom_range(255)), 1'b1);
        wait_quiet();

        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        random_traffic(words_sent + 320);
        tx_idle_pct = 78;
        rx_stall_pct <= 0;
        random_traffic(words_sent + 320);
        tx_idle_pct = 0;
        rx_stall_pct <= 78;
        random_traffic(words_sent + 320);
        tx_idle_pct = 15;
        rx_stall_pct <= 15;
        random_traffic(words_sent + 320);
        set_length(LEN_BITS'(PATTERN_MAX_DEF));
        search_buffer();

        in_valid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (sb.awaited.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (sb.awaited.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.awaited.size()));

        $display("run summary: %0d words sent, %0d results checked, %0d length settings",
                 words_sent, sb.results_checked, lengths_set);
        $display("covered empty and oversized patterns, late matches and a long hold-off");
        if (sb.mismatches == 0)
            $display("[byte_substring_search] OK");
        else
            $display("[byte_substring_search] ERROR");
        $finish;
    end

endmodule
